FILE: hdl/qtc_pkg.sv
// Shared constants and register codes for the QT clustering unit.
`timescale 1ns / 1ps
package qtc_pkg;
    localparam int IN_W      = 16;
    localparam int NUM_IN    = 8;
    localparam int CUT_W     = 16;
    localparam int PROD_W    = 2 * CUT_W;
    localparam int DIMS_W    = 4;
    localparam int TW        = PROD_W + DIMS_W;
    localparam int LABEL_W   = 7;
    localparam int IDX_OUT_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 2'd2;
endpackage

FILE: hdl/qtc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module qtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/qtc_lane.sv
// One coordinate lane: registered squared difference.
`timescale 1ns / 1ps
module qtc_lane #(
    parameter int CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CB-1:0] i_a,
    input  logic signed [CB-1:0] i_b,
    output logic [2*CB-1:0]      o_sq
);
    logic signed [CB:0] w_diff;
    logic [CB-1:0]      w_abs;
    logic [2*CB-1:0]    r_sq;

    assign w_diff = {i_a[CB-1], i_a} - {i_b[CB-1], i_b};
    assign w_abs  = w_diff[CB] ? CB'(-w_diff) : CB'(w_diff);

    always_ff @(posedge i_clk) begin
        r_sq <= i_en ? (2*CB)'(w_abs) * (2*CB)'(w_abs) : '0;
    end

    assign o_sq = r_sq;
endmodule

FILE: hdl/qtc_merge.sv
// Merge stage: registered sum of the lane squares.
`timescale 1ns / 1ps
module qtc_merge #(
    parameter int LANES = 8,
    parameter int SQW   = 32,
    parameter int DW    = 35
) (
    input  logic                       i_clk,
    input  logic [LANES-1:0][SQW-1:0]  i_sq,
    output logic [DW-1:0]              o_sum
);
    logic [DW-1:0] w_sum;
    logic [DW-1:0] r_sum;

    always_comb begin
        w_sum = '0;
        for (int d = 0; d < LANES; d++) begin
            w_sum = w_sum + DW'(i_sq[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= w_sum;
    end

    assign o_sum = r_sum;
endmodule

FILE: hdl/quality_threshold_clustering_unit.sv
// Load: each new point is compared with every stored point (one coordinate memory read per stored point, lanes, merge);
//   the first point of a data set has no stored point to compare with.
// Clustering: each growth pass reads the distance and farthest memories for every stored point;
//   a seed runs one pass per final member, every unlabelled seed each round.
// Output: n results, one at a time (label memory read, output register), each held while i_stall is high.
// Reset: synchronous active low; clears control state, memories are not cleared.
`timescale 1ns / 1ps
module quality_threshold_clustering_unit #(
    parameter int POINTS     = 64,
    parameter int DIMS       = 8,
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [qtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qtc_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_0,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_1,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_2,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_3,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_4,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_5,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_6,
    input  logic [qtc_pkg::IN_W-1:0]       i_coord_7,
    input  logic                           i_last_point,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [qtc_pkg::IDX_OUT_W-1:0]  o_point_index,
    output logic [qtc_pkg::LABEL_W-1:0]    o_cluster_label,
    output logic                           o_last_result,
    output logic                           o_points_dropped
);
    import qtc_pkg::*;

    localparam int IW  = $clog2(POINTS);
    localparam int CW  = IW + 1;
    localparam int SQW = 2 * COORD_BITS;
    localparam int DW  = SQW + $clog2(DIMS);
    localparam int RW  = DIMS * COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_DIST, S_THR0, S_THR1, S_SEED, S_PASS, S_LABEL, S_OUT
    } t_state;

    t_state               r_state;
    logic [CUT_W-1:0]     r_cutoff;
    logic                 r_metric;
    logic [DIMS_W-1:0]    r_dims;
    logic [CW-1:0]        r_count;
    logic                 r_over;
    logic                 r_last;
    logic [RW-1:0]        r_newc;
    logic [CW-1:0]        r_j;
    logic                 r_p1_valid;
    logic [IW-1:0]        r_p1_j;
    logic                 r_p2_valid;
    logic [IW-1:0]        r_p2_j;
    logic                 r_p3_valid;
    logic [IW-1:0]        r_p3_j;
    logic [PROD_W-1:0]    r_prod;
    logic [TW-1:0]        r_thr;
    logic [POINTS-1:0]    r_labelled;
    logic [POINTS-1:0]    r_members;
    logic [POINTS-1:0]    r_best_members;
    logic [CW-1:0]        r_size;
    logic [CW-1:0]        r_best_size;
    logic [CW-1:0]        r_seed;
    logic [IW-1:0]        r_pick;
    logic                 r_init;
    logic                 r_any;
    logic                 r_found;
    logic [DW-1:0]        r_min;
    logic [IW-1:0]        r_minj;
    logic [LABEL_W-1:0]   r_next_label;
    logic [CW-1:0]        r_k;
    logic                 r_rd_pend;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_o_valid;
    logic [IW-1:0]        r_o_idx;
    logic [LABEL_W-1:0]   r_o_label;
    logic                 r_o_last;

    logic [NUM_IN-1:0][IN_W-1:0] w_in;
    logic [RW-1:0]        w_newc;
    logic [DIMS_W-1:0]    w_nd;
    logic                 w_accept;
    logic                 w_issue;
    logic [RW-1:0]        w_coord_rd;
    logic [DIMS-1:0][SQW-1:0] w_sq;
    logic [DW-1:0]        w_sum;
    logic [IW-1:0]        w_jl;
    logic [IW-1:0]        w_hi;
    logic [IW-1:0]        w_lo;
    logic [DW-1:0]        w_dist_rd;
    logic [DW-1:0]        w_far_rd;
    logic [DW-1:0]        w_d;
    logic [DW-1:0]        w_nf;
    logic                 w_cand;
    logic                 w_lab_we;
    logic [LABEL_W-1:0]   w_label_rd;
    logic [TW-1:0]        w_scaled;

    always_comb begin
        w_in = {i_coord_7, i_coord_6, i_coord_5, i_coord_4,
                i_coord_3, i_coord_2, i_coord_1, i_coord_0};
        for (int d = 0; d < DIMS; d++) begin
            w_newc[d*COORD_BITS +: COORD_BITS] = w_in[d][COORD_BITS-1:0];
        end
    end

    always_comb begin
        if (r_dims == '0) begin
            w_nd = DIMS_W'(1);
        end else if (r_dims > DIMS_W'(DIMS)) begin
            w_nd = DIMS_W'(DIMS);
        end else begin
            w_nd = r_dims;
        end
    end

    // cutoff^2 * dims by shift and add, dims is at most four bits
    always_comb begin
        w_scaled = '0;
        for (int b = 0; b < DIMS_W; b++) begin
            if (w_nd[b]) begin
                w_scaled = w_scaled + (TW'(r_prod) << b);
            end
        end
    end

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_issue  = (r_state == S_DIST || r_state == S_PASS) && (r_j < r_count);
    assign w_jl     = r_j[IW-1:0];

    qtc_ram #(.WIDTH(RW), .DEPTH(POINTS)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (r_count < CW'(POINTS))),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_newc),
        .i_raddr (w_jl),
        .o_rdata (w_coord_rd)
    );

    for (genvar g = 0; g < DIMS; g++) begin : g_lane
        qtc_lane #(.CB(COORD_BITS)) u_lane (
            .i_clk (i_clk),
            .i_en  (r_p1_valid && (r_state == S_DIST) && (DIMS_W'(g) < w_nd)),
            .i_a   (r_newc[g*COORD_BITS +: COORD_BITS]),
            .i_b   (w_coord_rd[g*COORD_BITS +: COORD_BITS]),
            .o_sq  (w_sq[g])
        );
    end

    qtc_merge #(.LANES(DIMS), .SQW(SQW), .DW(DW)) u_merge (
        .i_clk (i_clk),
        .i_sq  (w_sq),
        .o_sum (w_sum)
    );

    // distances kept once per pair, row is the later point
    assign w_hi = (w_jl > r_pick) ? w_jl : r_pick;
    assign w_lo = (w_jl > r_pick) ? r_pick : w_jl;

    qtc_ram #(.WIDTH(DW), .DEPTH(1 << (2*IW))) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (r_p3_valid),
        .i_waddr ({r_count[IW-1:0], r_p3_j}),
        .i_wdata (w_sum),
        .i_raddr ({w_hi, w_lo}),
        .o_rdata (w_dist_rd)
    );

    assign w_d    = (r_p1_j == r_pick) ? '0 : w_dist_rd;
    assign w_nf   = (r_init || (w_d > w_far_rd)) ? w_d : w_far_rd;
    assign w_cand = !r_labelled[r_p1_j] && !r_members[r_p1_j];

    qtc_ram #(.WIDTH(DW), .DEPTH(POINTS)) u_far_ram (
        .i_clk   (i_clk),
        .i_we    (r_p1_valid && (r_state == S_PASS)),
        .i_waddr (r_p1_j),
        .i_wdata (w_nf),
        .i_raddr (w_jl),
        .o_rdata (w_far_rd)
    );

    assign w_lab_we = (r_state == S_LABEL) && (r_j < r_count) && r_best_members[w_jl];

    qtc_ram #(.WIDTH(LABEL_W), .DEPTH(POINTS)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_lab_we),
        .i_waddr (w_jl),
        .i_wdata (r_next_label),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (w_label_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cutoff     <= '0;
            r_metric     <= 1'b0;
            r_dims       <= DIMS_W'(1);
            r_count      <= '0;
            r_over       <= 1'b0;
            r_last       <= 1'b0;
            r_j          <= '0;
            r_p1_valid   <= 1'b0;
            r_p2_valid   <= 1'b0;
            r_p3_valid   <= 1'b0;
            r_labelled   <= '0;
            r_members    <= '0;
            r_best_members <= '0;
            r_size       <= '0;
            r_best_size  <= '0;
            r_seed       <= '0;
            r_init       <= 1'b0;
            r_any        <= 1'b0;
            r_found      <= 1'b0;
            r_next_label <= LABEL_W'(1);
            r_k          <= '0;
            r_rd_pend    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CUTOFF: r_cutoff <= i_cfg_data[CUT_W-1:0];
                    CFG_METRIC: r_metric <= i_cfg_data[0];
                    CFG_DIMS:   r_dims   <= i_cfg_data[DIMS_W-1:0];
                    default: ;
                endcase
            end

            r_p1_valid <= w_issue;
            r_p1_j     <= w_jl;
            r_p2_valid <= r_p1_valid && (r_state == S_DIST);
            r_p2_j     <= r_p1_j;
            r_p3_valid <= r_p2_valid;
            r_p3_j     <= r_p2_j;
            if (w_issue) begin
                r_j <= r_j + 1'b1;
            end

            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_last_point;
                        if (r_count < CW'(POINTS)) begin
                            r_newc  <= w_newc;
                            r_j     <= '0;
                            r_state <= S_DIST;
                        end else begin
                            r_over <= 1'b1;
                            if (i_last_point) begin
                                r_state <= S_THR0;
                            end
                        end
                    end
                end
                S_DIST: begin
                    if (r_j == r_count && !r_p1_valid && !r_p2_valid && !r_p3_valid) begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_last ? S_THR0 : S_IDLE;
                    end
                end
                S_THR0: begin
                    r_prod  <= PROD_W'(r_cutoff) * PROD_W'(r_cutoff);
                    r_state <= S_THR1;
                end
                S_THR1: begin
                    r_thr          <= r_metric ? w_scaled : TW'(r_prod);
                    r_seed         <= '0;
                    r_any          <= 1'b0;
                    r_best_size    <= '0;
                    r_best_members <= '0;
                    r_state        <= S_SEED;
                end
                S_SEED: begin
                    if (r_seed == r_count) begin
                        if (r_any) begin
                            r_j     <= '0;
                            r_state <= S_LABEL;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end
                    end else if (r_labelled[r_seed[IW-1:0]]) begin
                        r_seed <= r_seed + 1'b1;
                    end else begin
                        r_any     <= 1'b1;
                        r_members <= POINTS'(1) << r_seed[IW-1:0];
                        r_size    <= CW'(1);
                        r_pick    <= r_seed[IW-1:0];
                        r_init    <= 1'b1;
                        r_found   <= 1'b0;
                        r_j       <= '0;
                        r_state   <= S_PASS;
                    end
                end
                S_PASS: begin
                    if (r_p1_valid && w_cand && (!r_found || w_nf < r_min)) begin
                        r_found <= 1'b1;
                        r_min   <= w_nf;
                        r_minj  <= r_p1_j;
                    end
                    if (r_j == r_count && !r_p1_valid) begin
                        if (r_found && TW'(r_min) <= r_thr) begin
                            r_members <= r_members | (POINTS'(1) << r_minj);
                            r_size    <= r_size + 1'b1;
                            r_pick    <= r_minj;
                            r_init    <= 1'b0;
                            r_found   <= 1'b0;
                            r_j       <= '0;
                        end else begin
                            if (r_size > r_best_size) begin
                                r_best_size    <= r_size;
                                r_best_members <= r_members;
                            end
                            r_seed  <= r_seed + 1'b1;
                            r_state <= S_SEED;
                        end
                    end
                end
                S_LABEL: begin
                    if (r_j < r_count) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_labelled   <= r_labelled | r_best_members;
                        r_next_label <= r_next_label + 1'b1;
                        r_seed       <= '0;
                        r_any        <= 1'b0;
                        r_best_size  <= '0;
                        r_state      <= S_SEED;
                    end
                end
                S_OUT: begin
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_o_valid <= 1'b1;
                        r_o_idx   <= r_rd_idx;
                        r_o_label <= w_label_rd;
                        r_o_last  <= (CW'(r_rd_idx) + 1'b1) == r_count;
                    end else if (!r_o_valid) begin
                        if (r_k < r_count) begin
                            r_rd_pend <= 1'b1;
                            r_rd_idx  <= r_k[IW-1:0];
                            r_k       <= r_k + 1'b1;
                        end else begin
                            // data set done, back to empty
                            r_count      <= '0;
                            r_labelled   <= '0;
                            r_next_label <= LABEL_W'(1);
                            r_over       <= 1'b0;
                            r_last       <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_point_index    = IDX_OUT_W'(r_o_idx);
    assign o_cluster_label  = r_o_label;
    assign o_last_result    = r_o_last;
    assign o_points_dropped = r_over;

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_state == S_OUT)
        else $error("result valid outside output phase");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(POINTS))
        else $error("point count above capacity");

    a_pipe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (r_state == S_DIST || r_state == S_PASS))
        else $error("memory read pipeline active in wrong phase");

    a_label_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_label != '0)
        else $error("point emitted without a label");
endmodule
